// File: hw/rtl/wireworld_row_update_core_defines.svh
// assertion macros for the wireworld row update core
// depends on i_clk and i_rst_n being visible in the module that uses them
`ifndef WIREWORLD_ROW_UPDATE_CORE_DEFINES_SVH
`define WIREWORLD_ROW_UPDATE_CORE_DEFINES_SVH

// condition that holds at every edge out of reset
`define WWRU_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) else $error(msg);

// consequence checked in the cycle after the trigger
`define WWRU_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hw/rtl/wwru_pkg.sv
// shared types and constants for the wireworld row update core
// no dependencies
package wwru_pkg;

    localparam int ROW_W         = 64;
    localparam int CFG_W         = 6;
    localparam int GRID_COLS_DEF = 32;
    localparam int FIFO_DEPTH    = 4;
    localparam int FIFO_AW       = 2;
    localparam int FIFO_CW       = 3;

    localparam logic [CFG_W-1:0] ACTIVE_COLS_RST = 6'd32;

    typedef logic [ROW_W-1:0] t_row;
    typedef logic [1:0]       t_cell;

    localparam t_cell CELL_SPACE = 2'd0;
    localparam t_cell CELL_WIRE  = 2'd1;
    localparam t_cell CELL_HEAD  = 2'd2;
    localparam t_cell CELL_TAIL  = 2'd3;

endpackage

// File: hw/rtl/wwru_lane.sv
// one cell of the wire automaton: next state from own code and neighbour heads
// depends on wwru_pkg
module wwru_lane (
    input  wwru_pkg::t_cell i_cell,
    input  logic [7:0]      i_heads,
    output wwru_pkg::t_cell o_cell
);
    import wwru_pkg::*;

    logic [3:0] w_cnt;

    always_comb begin
        w_cnt = '0;
        for (int i = 0; i < 8; i++) begin
            w_cnt = w_cnt + 4'(i_heads[i]);
        end
    end

    always_comb begin
        case (i_cell)
            CELL_SPACE: o_cell = CELL_SPACE;
            CELL_TAIL:  o_cell = CELL_WIRE;
            CELL_HEAD:  o_cell = CELL_TAIL;
            CELL_WIRE:  o_cell = (w_cnt inside {4'd1, 4'd2}) ? CELL_HEAD : CELL_WIRE;
            default:    o_cell = CELL_SPACE;
        endcase
    end

endmodule

// File: hw/rtl/wwru_row_eval.sv
// one generation of a full row: column masking, a lane per column, row merge
// depends on wwru_pkg and wwru_lane
module wwru_row_eval #(
    parameter int GRID_COLS = wwru_pkg::GRID_COLS_DEF
) (
    input  logic [wwru_pkg::CFG_W-1:0] i_active_cols,
    input  wwru_pkg::t_row             i_up,
    input  wwru_pkg::t_row             i_mid,
    input  wwru_pkg::t_row             i_down,
    output wwru_pkg::t_row             o_row
);
    import wwru_pkg::*;

    logic [GRID_COLS-1:0] w_act;
    // head flags padded with space on both edges
    logic [GRID_COLS+1:0] w_hu;
    logic [GRID_COLS+1:0] w_hm;
    logic [GRID_COLS+1:0] w_hd;

    assign w_hu[0]           = 1'b0;
    assign w_hm[0]           = 1'b0;
    assign w_hd[0]           = 1'b0;
    assign w_hu[GRID_COLS+1] = 1'b0;
    assign w_hm[GRID_COLS+1] = 1'b0;
    assign w_hd[GRID_COLS+1] = 1'b0;

    for (genvar k = 0; k < GRID_COLS; k++) begin : g_col
        localparam logic [CFG_W-1:0] ColIdx = CFG_W'(k);
        t_cell w_centre;

        assign w_act[k]    = ColIdx < i_active_cols;
        assign w_hu[k+1]   = w_act[k] && (i_up[2*k +: 2] == CELL_HEAD);
        assign w_hm[k+1]   = w_act[k] && (i_mid[2*k +: 2] == CELL_HEAD);
        assign w_hd[k+1]   = w_act[k] && (i_down[2*k +: 2] == CELL_HEAD);
        assign w_centre    = w_act[k] ? i_mid[2*k +: 2] : CELL_SPACE;

        wwru_lane u_lane (
            .i_cell  (w_centre),
            .i_heads ({w_hu[k], w_hu[k+1], w_hu[k+2],
                       w_hm[k], w_hm[k+2],
                       w_hd[k], w_hd[k+1], w_hd[k+2]}),
            .o_cell  (o_row[2*k +: 2])
        );
    end

    if (GRID_COLS < ROW_W / 2) begin : g_pad
        assign o_row[ROW_W-1:2*GRID_COLS] = '0;
    end

endmodule

// File: hw/rtl/wireworld_row_update_core.sv
// top level of the wireworld row update core: row history, two row evaluators,
// result queue; depends on wwru_pkg, wwru_row_eval, wwru_lane and the defines header
//
//  channel  direction  handshake                  payload
//  input    in         i_in_valid / o_in_stall    i_row_cells, i_last_row
//  result   out        o_out_valid / i_out_stall  o_new_row, o_frame_end
//  config   in         i_cfg_we                   i_cfg_data (active_cols)
//
// one row transfer per cycle unless the input stalls; a row gives 0, 1 or 2 results, all registered
// two evaluators of GRID_COLS lanes each work in the transfer cycle, results go into a
// four entry queue; the input stalls while that queue holds more than two results
// a row that closes a grid of two or more rows gives two results, so such rows run at the output rate
// synchronous active low reset clears the rows-held state, queue pointers and count, and sets active_cols to 32
module wireworld_row_update_core
    import wwru_pkg::*;
#(
    parameter int GRID_COLS = wwru_pkg::GRID_COLS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    // configuration
    input  logic                       i_cfg_we,
    input  logic [wwru_pkg::CFG_W-1:0] i_cfg_data,
    // input rows
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  wwru_pkg::t_row             i_row_cells,
    input  logic                       i_last_row,
    // result rows
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output wwru_pkg::t_row             o_new_row,
    output logic                       o_frame_end
);
    `include "wireworld_row_update_core_defines.svh"

    typedef enum logic [1:0] {
        HELD_NONE,
        HELD_ONE,
        HELD_TWO
    } t_held;

    // row history
    t_held              r_rows_held;
    t_row               r_row_above;
    t_row               r_row_middle;
    logic [CFG_W-1:0]   r_active_cols;

    // result queue
    t_row               r_fifo_row [FIFO_DEPTH];
    logic               r_fifo_end [FIFO_DEPTH];
    logic [FIFO_AW-1:0] r_wr_ptr;
    logic [FIFO_AW-1:0] r_rd_ptr;
    logic [FIFO_CW-1:0] r_count;
    logic [FIFO_CW-1:0] n_count;

    logic               w_in_xfer;
    logic               w_pop;
    logic [1:0]         w_push_n;
    t_row               w_pend_up;
    t_row               w_last_up;
    t_row               w_row_pend;
    t_row               w_row_last;
    t_row               w_first_row;
    logic               w_first_end;

    // stall only looks at the queue fill, never at the output side
    assign o_in_stall = r_count > FIFO_CW'(FIFO_DEPTH - 2);
    assign w_in_xfer  = i_in_valid && !o_in_stall;
    assign w_pop      = o_out_valid && !i_out_stall;

    // pending row sees the row above only once two rows are held
    assign w_pend_up = (r_rows_held == HELD_TWO) ? r_row_above : '0;
    // a closing row sees the pending row above it, or space for a one-row grid
    assign w_last_up = (r_rows_held == HELD_NONE) ? '0 : r_row_middle;

    wwru_row_eval #(
        .GRID_COLS (GRID_COLS)
    ) u_eval_pend (
        .i_active_cols (r_active_cols),
        .i_up          (w_pend_up),
        .i_mid         (r_row_middle),
        .i_down        (i_row_cells),
        .o_row         (w_row_pend)
    );

    wwru_row_eval #(
        .GRID_COLS (GRID_COLS)
    ) u_eval_last (
        .i_active_cols (r_active_cols),
        .i_up          (w_last_up),
        .i_mid         (i_row_cells),
        .i_down        ('0),
        .o_row         (w_row_last)
    );

    // number of results a transfer adds and which one goes first
    always_comb begin
        w_push_n    = 2'd0;
        w_first_row = w_row_pend;
        w_first_end = 1'b0;
        if (w_in_xfer) begin
            if (r_rows_held == HELD_NONE) begin
                w_push_n    = i_last_row ? 2'd1 : 2'd0;
                w_first_row = w_row_last;
                w_first_end = 1'b1;
            end else begin
                w_push_n = i_last_row ? 2'd2 : 2'd1;
            end
        end
    end

    assign n_count = r_count + FIFO_CW'(w_push_n) - FIFO_CW'(w_pop);

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows_held   <= HELD_NONE;
            r_active_cols <= ACTIVE_COLS_RST;
            r_wr_ptr      <= '0;
            r_rd_ptr      <= '0;
            r_count       <= '0;
        end else begin
            if (i_cfg_we) begin
                r_active_cols <= i_cfg_data;
            end
            if (w_in_xfer) begin
                if (i_last_row) begin
                    r_rows_held <= HELD_NONE;
                end else if (r_rows_held == HELD_NONE) begin
                    r_rows_held <= HELD_ONE;
                end else begin
                    r_rows_held <= HELD_TWO;
                end
            end
            r_wr_ptr <= r_wr_ptr + FIFO_AW'(w_push_n);
            r_rd_ptr <= r_rd_ptr + FIFO_AW'(w_pop);
            r_count  <= n_count;
        end
    end

    // row history and queue payload, no reset needed
    always_ff @(posedge i_clk) begin
        if (w_in_xfer && !i_last_row) begin
            r_row_above  <= r_row_middle;
            r_row_middle <= i_row_cells;
        end
        if (w_push_n != 2'd0) begin
            r_fifo_row[r_wr_ptr] <= w_first_row;
            r_fifo_end[r_wr_ptr] <= w_first_end;
        end
        if (w_push_n == 2'd2) begin
            r_fifo_row[r_wr_ptr + FIFO_AW'(1)] <= w_row_last;
            r_fifo_end[r_wr_ptr + FIFO_AW'(1)] <= 1'b1;
        end
    end

    assign o_out_valid = r_count != '0;
    assign o_new_row   = r_fifo_row[r_rd_ptr];
    assign o_frame_end = r_fifo_end[r_rd_ptr];

    `WWRU_ASSERT_ALWAYS(a_fifo_bound, r_count <= FIFO_CW'(FIFO_DEPTH), "result queue overfilled")
    `WWRU_ASSERT_NEXT(a_last_clears, w_in_xfer && i_last_row, r_rows_held == HELD_NONE, "history not cleared after closing row")
    `WWRU_ASSERT_NEXT(a_store_only, w_in_xfer && !i_last_row && r_rows_held == HELD_NONE, r_count == $past(r_count) - FIFO_CW'($past(w_pop)), "first row produced a result")
    `WWRU_ASSERT_NEXT(a_emit_count, w_in_xfer && r_rows_held != HELD_NONE, r_count == $past(r_count) + FIFO_CW'(1) + FIFO_CW'($past(i_last_row)) - FIFO_CW'($past(w_pop)), "wrong number of results queued")

endmodule
